/* sv/nnd_pkg.sv */
// Package for the nearest-neighbor RGB565 downscaler.
// Holds register indexes, reset sizes and pixel field positions; no dependencies.
`default_nettype none

package nnd_pkg;

    // Configuration port
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOURCE_WIDTH  = 8'd0,
        REG_SOURCE_HEIGHT = 8'd1,
        REG_TARGET_WIDTH  = 8'd2,
        REG_TARGET_HEIGHT = 8'd3
    } cfg_reg_t;

    localparam logic [CFG_DATA_W-1:0] SOURCE_WIDTH_RST  = 11'd320;
    localparam logic [CFG_DATA_W-1:0] SOURCE_HEIGHT_RST = 11'd240;
    localparam logic [CFG_DATA_W-1:0] TARGET_WIDTH_RST  = 11'd96;
    localparam logic [CFG_DATA_W-1:0] TARGET_HEIGHT_RST = 11'd96;

    // RGB565 field layout
    localparam int PIXEL_W   = 16;
    localparam int RED_LSB   = 11;
    localparam int GREEN_LSB = 5;
    localparam int RED_W     = 5;
    localparam int GREEN_W   = 6;
    localparam int BLUE_W    = 5;
    localparam int CHAN_W    = 8;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb888_t;

    localparam int RGB888_W = $bits(rgb888_t);

    // Widen RGB565 to RGB888 by left shifts
    function automatic rgb888_t widen_rgb565(input logic [PIXEL_W-1:0] pix);
        rgb888_t c;
        c.red   = {pix[RED_LSB +: RED_W], (CHAN_W - RED_W)'(0)};
        c.green = {pix[GREEN_LSB +: GREEN_W], (CHAN_W - GREEN_W)'(0)};
        c.blue  = {pix[0 +: BLUE_W], (CHAN_W - BLUE_W)'(0)};
        return c;
    endfunction

endpackage

`default_nettype wire

/* sv/nnd_cfg_regs.sv */
// Size registers of the downscaler and their effective (clamped) values.
// Depends on nnd_pkg.
`default_nettype none

module nnd_cfg_regs
    import nnd_pkg::*;
#(
    parameter int COORD_BITS = 10
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic      [COORD_BITS:0]   src_w,
    output logic      [COORD_BITS:0]   src_h,
    output logic      [COORD_BITS:0]   dst_w,
    output logic      [COORD_BITS:0]   dst_h
);

    localparam int CMP_W = (COORD_BITS + 1 > CFG_DATA_W) ? COORD_BITS + 1 : CFG_DATA_W;
    localparam logic [CMP_W-1:0] DIM_MAX = CMP_W'(2 ** COORD_BITS);

    logic [CFG_DATA_W-1:0] src_w_reg, src_w_next;
    logic [CFG_DATA_W-1:0] src_h_reg, src_h_next;
    logic [CFG_DATA_W-1:0] dst_w_reg, dst_w_next;
    logic [CFG_DATA_W-1:0] dst_h_reg, dst_h_next;

    // Zero reads as one, sizes above the coordinate range saturate
    function automatic logic [COORD_BITS:0] eff_dim(input logic [CFG_DATA_W-1:0] r);
        logic [CMP_W-1:0] v;
        v = CMP_W'(r);
        if (v == '0) begin
            v = CMP_W'(1);
        end
        if (v > DIM_MAX) begin
            v = DIM_MAX;
        end
        return v[COORD_BITS:0];
    endfunction

    // Register write decode; unknown indexes are dropped
    always_comb begin
        src_w_next = src_w_reg;
        src_h_next = src_h_reg;
        dst_w_next = dst_w_reg;
        dst_h_next = dst_h_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_SOURCE_WIDTH:  src_w_next = cfg_data;
                REG_SOURCE_HEIGHT: src_h_next = cfg_data;
                REG_TARGET_WIDTH:  dst_w_next = cfg_data;
                REG_TARGET_HEIGHT: dst_h_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg <= SOURCE_WIDTH_RST;
            src_h_reg <= SOURCE_HEIGHT_RST;
            dst_w_reg <= TARGET_WIDTH_RST;
            dst_h_reg <= TARGET_HEIGHT_RST;
        end else begin
            src_w_reg <= src_w_next;
            src_h_reg <= src_h_next;
            dst_w_reg <= dst_w_next;
            dst_h_reg <= dst_h_next;
        end
    end

    assign src_w = eff_dim(src_w_reg);
    assign src_h = eff_dim(src_h_reg);
    assign dst_w = eff_dim(dst_w_reg);
    assign dst_h = eff_dim(dst_h_reg);

endmodule

`default_nettype wire

/* sv/nnd_select.sv */
// Raster counters and error terms that pick the source pixels to keep.
// Depends on nnd_pkg.
`default_nettype none

module nnd_select
    import nnd_pkg::*;
#(
    parameter int COORD_BITS = 10,
    parameter int DATA_W     = RGB888_W + 2 * COORD_BITS + 1
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  accept,
    input  wire logic [PIXEL_W-1:0]    pixel,
    input  wire logic [COORD_BITS:0]   src_w,
    input  wire logic [COORD_BITS:0]   src_h,
    input  wire logic [COORD_BITS:0]   dst_w,
    input  wire logic [COORD_BITS:0]   dst_h,
    output logic                       push,
    output logic      [DATA_W-1:0]     push_data
);

    // Error terms stay within about +/- 2*size; one spare bit for the add
    localparam int ERR_W = COORD_BITS + 3;

    logic        [COORD_BITS-1:0] src_col_reg, src_col_next;
    logic        [COORD_BITS-1:0] src_row_reg, src_row_next;
    logic        [COORD_BITS-1:0] out_col_reg, out_col_next;
    logic        [COORD_BITS-1:0] out_row_reg, out_row_next;
    logic signed [ERR_W-1:0]      col_err_reg, col_err_next;
    logic signed [ERR_W-1:0]      row_err_reg, row_err_next;

    logic                         col_sel, row_sel;
    logic                         row_last, frame_last;
    logic                         last_pixel;
    logic signed [ERR_W-1:0]      col_err_adv, row_err_adv;
    rgb888_t                      color;

    // Selection: 0 <= err < dst size and destination index still in range
    assign col_sel = !col_err_reg[ERR_W-1]
                  && (col_err_reg[ERR_W-2:0] < {1'b0, dst_w})
                  && ({1'b0, out_col_reg} < dst_w);
    assign row_sel = !row_err_reg[ERR_W-1]
                  && (row_err_reg[ERR_W-2:0] < {1'b0, dst_h})
                  && ({1'b0, out_row_reg} < dst_h);

    assign row_last   = (({1'b0, src_col_reg} + 1'b1) >= src_w);
    assign frame_last = (({1'b0, src_row_reg} + 1'b1) >= src_h);

    // Negative error is held until the row or frame restarts
    assign col_err_adv = col_err_reg[ERR_W-1] ? col_err_reg
                       : col_err_reg - $signed({2'b00, dst_w})
                         + (col_sel ? $signed({2'b00, src_w}) : ERR_W'(0));
    assign row_err_adv = row_err_reg[ERR_W-1] ? row_err_reg
                       : row_err_reg - $signed({2'b00, dst_h})
                         + (row_sel ? $signed({2'b00, src_h}) : ERR_W'(0));

    // Counter update per accepted pixel
    always_comb begin
        src_col_next = src_col_reg;
        src_row_next = src_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        col_err_next = col_err_reg;
        row_err_next = row_err_reg;
        if (accept) begin
            if (row_last) begin
                src_col_next = '0;
                out_col_next = '0;
                col_err_next = '0;
                if (frame_last) begin
                    src_row_next = '0;
                    out_row_next = '0;
                    row_err_next = '0;
                end else begin
                    row_err_next = row_err_adv;
                    src_row_next = src_row_reg + 1'b1;
                    if (row_sel) begin
                        out_row_next = out_row_reg + 1'b1;
                    end
                end
            end else begin
                col_err_next = col_err_adv;
                src_col_next = src_col_reg + 1'b1;
                if (col_sel) begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_col_reg <= '0;
            src_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            col_err_reg <= '0;
            row_err_reg <= '0;
        end else begin
            src_col_reg <= src_col_next;
            src_row_reg <= src_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            col_err_reg <= col_err_next;
            row_err_reg <= row_err_next;
        end
    end

    // Result for the output buffer
    assign last_pixel = (({1'b0, out_col_reg} + 1'b1) == dst_w)
                     && (({1'b0, out_row_reg} + 1'b1) == dst_h);
    assign color      = widen_rgb565(pixel);
    assign push       = accept && col_sel && row_sel;
    assign push_data  = {color, out_col_reg, out_row_reg, last_pixel};

endmodule

`default_nettype wire

/* sv/nnd_out_buf.sv */
// Two-entry output register with skid slot for the result channel.
// Does not depend on nnd_pkg; no imports needed.
`default_nettype none

module nnd_out_buf #(
    parameter int DATA_W = 45
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   push_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic      [DATA_W-1:0] m_data
);

    logic              main_valid_reg, main_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [DATA_W-1:0] main_data_reg, main_data_next;
    logic [DATA_W-1:0] skid_data_reg, skid_data_next;
    logic              pop;

    assign pop = main_valid_reg && m_ready;

    // Skid slot refills the main register; new results land where there is room
    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_data_next  = push_data;
                main_valid_next = 1'b1;
            end else begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign push_ready = !skid_valid_reg;
    assign m_valid    = main_valid_reg;
    assign m_data     = main_data_reg;

endmodule

`default_nettype wire

/* sv/nearest_neighbor_downscale_rgb565.sv */
// Top level of the nearest-neighbor RGB565 to RGB888 downscaler.
// Depends on nnd_pkg, nnd_cfg_regs, nnd_select and nnd_out_buf.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+----------------------
//  input   | s_pixel_in                              | s_valid / s_ready
//  result  | m_red_out m_green_out m_blue_out        | m_valid / m_ready
//          | m_out_column m_out_row m_frame_end      |
//  config  | cfg_index cfg_data                      | cfg_wr_en, no wait
//
// One source pixel per cycle while s_ready is high; counters and error terms
// update in the transfer cycle, and a kept pixel is registered before m_*.
// Throughput is set by the two-entry output buffer: s_ready drops only when
// both entries hold results, so a stalled sink stops input after two results.
// Reset (aresetn, synchronous, active low) restores the default sizes and
// restarts the frame at row and column zero. No clearing pass is needed.
`default_nettype none

module nearest_neighbor_downscale_rgb565
    import nnd_pkg::*;
#(
    parameter int COORD_BITS = 10
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // source pixels
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [PIXEL_W-1:0]    s_pixel_in,
    // destination pixels
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [CHAN_W-1:0]     m_red_out,
    output logic      [CHAN_W-1:0]     m_green_out,
    output logic      [CHAN_W-1:0]     m_blue_out,
    output logic      [COORD_BITS-1:0] m_out_column,
    output logic      [COORD_BITS-1:0] m_out_row,
    output logic                       m_frame_end
);

    localparam int DATA_W = RGB888_W + 2 * COORD_BITS + 1;

    logic [COORD_BITS:0] src_w, src_h, dst_w, dst_h;
    logic                accept;
    logic                push;
    logic [DATA_W-1:0]   push_data;
    logic [DATA_W-1:0]   m_data;
    rgb888_t             m_color;

    nnd_cfg_regs #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .src_w     (src_w),
        .src_h     (src_h),
        .dst_w     (dst_w),
        .dst_h     (dst_h)
    );

    // Input transfer
    assign accept = s_valid && s_ready;

    nnd_select #(
        .COORD_BITS (COORD_BITS),
        .DATA_W     (DATA_W)
    ) u_select (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .pixel     (s_pixel_in),
        .src_w     (src_w),
        .src_h     (src_h),
        .dst_w     (dst_w),
        .dst_h     (dst_h),
        .push      (push),
        .push_data (push_data)
    );

    nnd_out_buf #(
        .DATA_W (DATA_W)
    ) u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .push_ready (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // Unpack the buffered result
    assign m_color      = m_data[DATA_W-1 -: RGB888_W];
    assign m_red_out    = m_color.red;
    assign m_green_out  = m_color.green;
    assign m_blue_out   = m_color.blue;
    assign m_out_column = m_data[2*COORD_BITS -: COORD_BITS];
    assign m_out_row    = m_data[COORD_BITS -: COORD_BITS];
    assign m_frame_end  = m_data[0];

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for nearest_neighbor_downscale_rgb565.
// Depends on nnd_pkg and the block's RTL. It predicts every kept pixel from the
// size registers and compares each result transfer against the oldest prediction.
`timescale 1ns / 100ps

module testbench;
    import nnd_pkg::*;

    localparam int COORD_BITS   = 10;
    localparam int MAX_SIZE     = 1 << COORD_BITS;
    localparam int LIMIT_CYCLES = 600000;
    localparam int RANDOM_ITEMS = 1100;
    localparam int CALM_ITEMS   = 150;
    localparam int SETTLE       = 4;
    localparam int MAX_REPORTS  = 10;

    // Register indexes that the block must ignore
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE = 8'd4;
    localparam logic [CFG_IDX_W-1:0] IDX_TOP   = 8'hFF;

    typedef struct packed {
        logic [CHAN_W-1:0]     red;
        logic [CHAN_W-1:0]     green;
        logic [CHAN_W-1:0]     blue;
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic                  last;
    } dst_pixel_t;

    typedef enum logic [1:0] {ROW_WRITE, ROW_PIXEL, ROW_PIXEL_KNOWN} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        logic [PIXEL_W-1:0]     pix;
        logic                   hit;
        dst_pixel_t             want;
    } stim_row_t;

    localparam int N_DIRECTED = 45;

    // Directed rows: known results are written out only where they are obvious
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        // reset sizes 320x240 -> 96x96, first pixel is always kept
        '{ROW_PIXEL_KNOWN, 8'd0, 11'd0, 16'hFFFF, 1'b1,
          '{8'hF8, 8'hFC, 8'hF8, 10'd0, 10'd0, 1'b0}},
        '{ROW_PIXEL, 8'd0, 11'd0, 16'h0000, 1'b0, '0},
        // 1x1 frames, written mid-row so the counters wrap
        '{ROW_WRITE, REG_SOURCE_WIDTH,  11'd1, 16'h0, 1'b0, '0},
        '{ROW_WRITE, REG_SOURCE_HEIGHT, 11'd1, 16'h0, 1'b0, '0},
        '{ROW_WRITE, REG_TARGET_WIDTH,  11'd1, 16'h0, 1'b0, '0},
        '{ROW_WRITE, REG_TARGET_HEIGHT, 11'd1, 16'h0, 1'b0, '0},
        '{ROW_PIXEL, 8'd0, 11'd0, 16'hF800, 1'b0, '0},
        '{ROW_PIXEL_KNOWN, 8'd0, 11'd0, 16'h07E0, 1'b1,
          '{8'h00, 8'hFC, 8'h00, 10'd0, 10'd0, 1'b1}},
        '{ROW_PIXEL_KNOWN, 8'd0, 11'd0, 16'h001F, 1'b1,
          '{8'h00, 8'h00, 8'hF8, 10'd0, 10'd0, 1'b1}},
        // zero sizes count as one
        '{ROW_WRITE, REG_SOURCE_WIDTH,  11'd0, 16'h0, 1'b0, '0},
        '{ROW_WRITE, REG_SOURCE_HEIGHT, 11'd0, 16'h0, 1'b0, '0},
        '{ROW_WRITE, REG_TARGET_WIDTH,  11'd0, 16'h0, 1'b0, '0},
        '{ROW_WRITE, REG_TARGET_HEIGHT, 11'd0, 16'h0, 1'b0, '0},
        '{ROW_PIXEL_KNOWN, 8'd0, 11'd0, 16'h8421, 1'b1,
          '{8'h80, 8'h84, 8'h08, 10'd0, 10'd0, 1'b1}},
        // writes to unused indexes change nothing
        '{ROW_WRITE, IDX_SPARE, 11'd2047, 16'h0, 1'b0, '0},
        '{ROW_WRITE, IDX_TOP,   11'd2047, 16'h0, 1'b0, '0},
        '{ROW_PIXEL_KNOWN, 8'd0, 11'd0, 16'h7BEF, 1'b1,
          '{8'h78, 8'h7C, 8'h78, 10'd0, 10'd0, 1'b1}},
        // oversized widths saturate, one-to-one columns
        '{ROW_WRITE, REG_SOURCE_WIDTH,  11'd2047, 16'h0, 1'b0, '0},
        '{ROW_WRITE, REG_SOURCE_HEIGHT, 11'd2,    16'h0, 1'b0, '0},
        '{ROW_WRITE, REG_TARGET_WIDTH,  11'd2047, 16'h0, 1'b0, '0},
        '{ROW_WRITE, REG_TARGET_HEIGHT, 11'd1,    16'h0, 1'b0, '0},
        '{ROW_PIXEL_KNOWN, 8'd0, 11'd0, 16'hAAAA, 1'b1,
          '{8'hA8, 8'h54, 8'h50, 10'd0, 10'd0, 1'b0}},
        '{ROW_PIXEL_KNOWN, 8'd0, 11'd0, 16'h5555, 1'b1,
          '{8'h50, 8'hA8, 8'hA8, 10'd1, 10'd0, 1'b0}},
        '{ROW_PIXEL_KNOWN, 8'd0, 11'd0, 16'h0001, 1'b1,
          '{8'h00, 8'h00, 8'h08, 10'd2, 10'd0, 1'b0}},
        // destination larger than source
        '{ROW_WRITE, REG_SOURCE_WIDTH,  11'd3, 16'h0, 1'b0, '0},
        '{ROW_WRITE, REG_SOURCE_HEIGHT, 11'd2, 16'h0, 1'b0, '0},
        '{ROW_WRITE, REG_TARGET_WIDTH,  11'd5, 16'h0, 1'b0, '0},
        '{ROW_WRITE, REG_TARGET_HEIGHT, 11'd4, 16'h0, 1'b0, '0},
        '{ROW_PIXEL, 8'd0, 11'd0, 16'h1234, 1'b0, '0},
        '{ROW_PIXEL, 8'd0, 11'd0, 16'hFEDC, 1'b0, '0},
        '{ROW_PIXEL, 8'd0, 11'd0, 16'h8000, 1'b0, '0},
        '{ROW_PIXEL, 8'd0, 11'd0, 16'h0800, 1'b0, '0},
        '{ROW_PIXEL, 8'd0, 11'd0, 16'h0020, 1'b0, '0},
        '{ROW_PIXEL, 8'd0, 11'd0, 16'h0010, 1'b0, '0},
        // plain downscale, destination row full before the source row ends
        '{ROW_WRITE, REG_SOURCE_WIDTH,  11'd7, 16'h0, 1'b0, '0},
        '{ROW_WRITE, REG_SOURCE_HEIGHT, 11'd5, 16'h0, 1'b0, '0},
        '{ROW_WRITE, REG_TARGET_WIDTH,  11'd3, 16'h0, 1'b0, '0},
        '{ROW_WRITE, REG_TARGET_HEIGHT, 11'd2, 16'h0, 1'b0, '0},
        '{ROW_PIXEL, 8'd0, 11'd0, 16'h4000, 1'b0, '0},
        '{ROW_PIXEL, 8'd0, 11'd0, 16'h0400, 1'b0, '0},
        '{ROW_PIXEL, 8'd0, 11'd0, 16'h0040, 1'b0, '0},
        '{ROW_PIXEL, 8'd0, 11'd0, 16'h0004, 1'b0, '0},
        '{ROW_PIXEL, 8'd0, 11'd0, 16'hFFFE, 1'b0, '0},
        '{ROW_PIXEL, 8'd0, 11'd0, 16'h7FFF, 1'b0, '0},
        '{ROW_PIXEL, 8'd0, 11'd0, 16'hC3A5, 1'b0, '0}
    };

    logic                   aclk;
    logic                   aresetn     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;
    logic                   s_valid     = 1'b0;
    logic                   s_ready;
    logic [PIXEL_W-1:0]     s_pixel_in  = '0;
    logic                   m_valid;
    logic                   m_ready     = 1'b0;
    logic [CHAN_W-1:0]      m_red_out;
    logic [CHAN_W-1:0]      m_green_out;
    logic [CHAN_W-1:0]      m_blue_out;
    logic [COORD_BITS-1:0]  m_out_column;
    logic [COORD_BITS-1:0]  m_out_row;
    logic                   m_frame_end;

    nearest_neighbor_downscale_rgb565 #(.COORD_BITS(COORD_BITS)) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_in   (s_pixel_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red_out    (m_red_out),
        .m_green_out  (m_green_out),
        .m_blue_out   (m_blue_out),
        .m_out_column (m_out_column),
        .m_out_row    (m_out_row),
        .m_frame_end  (m_frame_end)
    );

    // Size registers as the block should hold them
    logic [CFG_DATA_W-1:0] src_w_reg = SOURCE_WIDTH_RST;
    logic [CFG_DATA_W-1:0] src_h_reg = SOURCE_HEIGHT_RST;
    logic [CFG_DATA_W-1:0] dst_w_reg = TARGET_WIDTH_RST;
    logic [CFG_DATA_W-1:0] dst_h_reg = TARGET_HEIGHT_RST;

    // Scan position and next destination slot, with the two error terms
    logic [COORD_BITS-1:0] scan_col = '0;
    logic [COORD_BITS-1:0] scan_row = '0;
    logic [COORD_BITS-1:0] fill_col = '0;
    logic [COORD_BITS-1:0] fill_row = '0;
    int                    col_err  = 0;
    int                    row_err  = 0;

    dst_pixel_t pending_pixels [$];

    int idle_odds      = 0;   // 0: no idling, else one chance in idle_odds
    int cycle_count    = 0;
    int mismatches     = 0;
    int pixels_sent    = 0;
    int pixels_checked = 0;
    int settings_used  = 0;

    // 10 ns clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Zero counts as one, anything past the coordinate range saturates
    function automatic int clamp_size(input logic [CFG_DATA_W-1:0] r);
        if (r == 0) return 1;
        if (int'(r) > MAX_SIZE) return MAX_SIZE;
        return int'(r);
    endfunction

    // An error term that went negative stays there until its row or frame ends
    function automatic int step_error(input int err, input bit taken, input int dst,
                                      input int src);
        if (err < 0) return err;
        return err - dst + (taken ? src : 0);
    endfunction

    // Advance the scan by one source pixel; returns 1 when it is kept
    function automatic bit pick_and_widen(input logic [PIXEL_W-1:0] pix,
                                          output dst_pixel_t px);
        int  sw, sh, dw, dh;
        bit  col_hit, row_hit;
        sw = clamp_size(src_w_reg);
        sh = clamp_size(src_h_reg);
        dw = clamp_size(dst_w_reg);
        dh = clamp_size(dst_h_reg);
        col_hit = col_err >= 0 && col_err < dw && int'(fill_col) < dw;
        row_hit = row_err >= 0 && row_err < dh && int'(fill_row) < dh;
        px.red   = {pix[15:11], 3'b000};
        px.green = {pix[10:5], 2'b00};
        px.blue  = {pix[4:0], 3'b000};
        px.col   = fill_col;
        px.row   = fill_row;
        px.last  = (int'(fill_col) + 1 == dw) && (int'(fill_row) + 1 == dh);

        if (int'(scan_col) + 1 >= sw) begin
            // source row done
            scan_col = '0;
            fill_col = '0;
            col_err  = 0;
            if (int'(scan_row) + 1 >= sh) begin
                scan_row = '0;
                fill_row = '0;
                row_err  = 0;
            end else begin
                row_err = step_error(row_err, row_hit, dh, sh);
                if (row_hit) fill_row = fill_row + 1'b1;
                scan_row = scan_row + 1'b1;
            end
        end else begin
            col_err = step_error(col_err, col_hit, dw, sw);
            if (col_hit) fill_col = fill_col + 1'b1;
            scan_col = scan_col + 1'b1;
        end
        return col_hit && row_hit;
    endfunction

    function automatic string show(input dst_pixel_t p);
        return $sformatf("rgb %02h/%02h/%02h at (%0d,%0d) end %0b",
                         p.red, p.green, p.blue, p.col, p.row, p.last);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] extreme_size();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return 11'd1;
            2: return 11'(MAX_SIZE);
            3: return '1;
            default: return 11'($urandom_range(0, 2047));
        endcase
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Drain every pending pixel, then let the pipeline settle
    task automatic settle();
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Register write, only with the block idle; leaves cfg_wr_en low
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        s_valid   <= 1'b0;
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_SOURCE_WIDTH:  src_w_reg = data;
            REG_SOURCE_HEIGHT: src_h_reg = data;
            REG_TARGET_WIDTH:  dst_w_reg = data;
            REG_TARGET_HEIGHT: dst_h_reg = data;
            default: ;
        endcase
    endtask

    // One source pixel transfer; a known result replaces the computed one
    task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input bit known,
                              input bit known_hit, input dst_pixel_t known_px);
        dst_pixel_t px;
        bit         hit;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_pixel_in <= pix;
        do @(posedge aclk); while (!s_ready);
        pixels_sent++;
        hit = pick_and_widen(pix, px);
        if (known) begin
            hit = known_hit;
            px  = known_px;
        end
        if (hit) pending_pixels.push_back(px);
    endtask

    // Result side: random stall bursts and the comparison
    int stall_left = 0;
    always @(posedge aclk) begin
        dst_pixel_t got, want;
        if (m_valid && m_ready) begin
            got = '{m_red_out, m_green_out, m_blue_out, m_out_column, m_out_row,
                    m_frame_end};
            if (pending_pixels.size() == 0) begin
                flag_error($sformatf("unexpected result %s", show(got)));
            end else begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.col !== want.col ||
                    got.row !== want.row || got.last !== want.last)
                    flag_error($sformatf("expected %s, got %s", show(want), show(got)));
            end
        end
        if (idle_odds != 0 && stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            stall_left = $urandom_range(1, 18) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d pixels still pending",
                     cycle_count, pending_pixels.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Stimulus
    initial begin
        stim_row_t  r;
        int         sw, sh, dw, dh, n, frame, random_sent;
        idle_odds = 6;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part
        for (int i = 0; i < N_DIRECTED; i++) begin
            r = DIRECTED[i];
            if (r.kind == ROW_WRITE) begin
                cfg_write(r.idx, r.data);
                if (i == 0 || DIRECTED[i-1].kind != ROW_WRITE) settings_used++;
            end else begin
                send_pixel(r.pix, r.kind == ROW_PIXEL_KNOWN, r.hit, r.want);
            end
        end

        // random phases, each under a fresh size setting
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent >= RANDOM_ITEMS - CALM_ITEMS) begin
                idle_odds = 0;
            end else begin
                case ($urandom_range(0, 3))
                    0: idle_odds = 0;
                    1: idle_odds = 3;
                    2: idle_odds = 8;
                    default: idle_odds = 20;
                endcase
            end
            case ($urandom_range(0, 19)) inside
                [0:10]: begin
                    sw = $urandom_range(1, 16);
                    sh = $urandom_range(1, 8);
                    dw = $urandom_range(1, sw);
                    dh = $urandom_range(1, sh);
                end
                [11:13]: begin
                    // destination larger than source
                    sw = $urandom_range(1, 8);
                    sh = $urandom_range(1, 6);
                    dw = $urandom_range(sw, sw + 8);
                    dh = $urandom_range(sh, sh + 4);
                end
                [14:15]: begin
                    sw = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                    sh = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                    dw = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                    dh = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                end
                default: begin
                    sw = extreme_size();
                    sh = extreme_size();
                    dw = extreme_size();
                    dh = extreme_size();
                end
            endcase
            cfg_write(REG_SOURCE_WIDTH, 11'(sw));
            cfg_write(REG_SOURCE_HEIGHT, 11'(sh));
            cfg_write(REG_TARGET_WIDTH, 11'(dw));
            cfg_write(REG_TARGET_HEIGHT, 11'(dh));
            if ($urandom_range(0, 3) == 0)
                cfg_write(CFG_IDX_W'($urandom_range(IDX_SPARE, IDX_TOP)),
                          CFG_DATA_W'($urandom_range(0, 2047)));
            settings_used++;

            frame = clamp_size(11'(sw)) * clamp_size(11'(sh));
            if (frame <= 128) n = $urandom_range(1, 3 * frame + 5);
            else n = $urandom_range(20, 160);
            if (n > 160) n = 160;
            repeat (n) send_pixel(PIXEL_W'($urandom_range(0, 65535)), 1'b0, 1'b0, '0);
            random_sent += n;
        end

        // wind down
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("covered %0d source pixels under %0d size settings", pixels_sent,
                 settings_used);
        $display("compared %0d destination pixels, %0d mismatches", pixels_checked,
                 mismatches);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/nnd_pkg.sv
sv/nnd_cfg_regs.sv
sv/nnd_select.sv
sv/nnd_out_buf.sv
sv/nearest_neighbor_downscale_rgb565.sv
tb/sv/testbench.sv
